@@ design/gemv_pkg.sv @@
// Shared types, constants and lane control for the four-row block-scaled GEMV stream.
`default_nettype none
package gemv_pkg;

    localparam int BLOCK_LEN      = 32;
    localparam int ITEMS_PER_BLK  = BLOCK_LEN / 4;
    localparam int CNT_W          = $clog2(ITEMS_PER_BLK + 1);

    localparam int WORD_W   = 32;
    localparam int SCALE_W  = 24;
    localparam int ACT_W    = 8;
    localparam int DOT_W    = 21;
    localparam int SUM_W    = 13;
    localparam int ITSUM_W  = 10;
    localparam int ACC_W    = 56;
    localparam int RES_W    = 64;

    localparam logic [1:0] KIND_WSCALE = 2'd0;
    localparam logic [1:0] KIND_MTERM  = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [SCALE_W-1:0] ACT_SCALE_RST = 24'd65536;

    // Four activations with the offset removed, element 0 in the lowest bits.
    typedef logic [3:0][ACT_W-1:0] act_vec_t;

    typedef struct packed {
        logic load_ws;
        logic load_mt;
        logic acc_en;
        logic mul_en;
        logic add_en;
        logic sc_lo;
        logic sc_hi;
        logic sc_done;
    } lane_ctrl_t;

endpackage
`default_nettype wire

@@ design/int8_block_scaled_gemv_four_rows_top.sv @@
// Top level: stream ports, sequencer, activation sum, four row lanes and the result register.
`default_nettype none
// Four-row block-quantised int8 matrix-vector stream. Header requests load the per-row
// weight scales (kind 0) or minimum terms (kind 1); data requests (kind 2) carry four
// signed weight bytes per row and four offset-128 activation bytes. Headers and data
// requests that do not close a block stream at one per cycle while the block is idle.
// A request that closes a block (end_block, end_group or the eighth request of a block)
// holds the input through ST_MUL and ST_ADD while each lane multiplies and updates its
// row sum; one with end_group then goes through ST_SCLO and ST_SCHI for the two-half
// scaling multiply, then loads the result register in ST_OUT once any earlier result
// has been taken. The act_scale register may be written whenever the block is idle.
module int8_block_scaled_gemv_four_rows_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [23:0]  cfg_data,     // act_scale
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [159:0] s_tdata,      // row0_word, row1_word, row2_word, row3_word, act_bytes
    input  wire logic [2:0]   s_tuser,      // kind[1:0], end_block[2]
    input  wire logic         s_tlast,      // end_group
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata       // row0_result, row1_result, row2_result, row3_result
);
    import gemv_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_SCLO = 6'b001000,
        ST_SCHI = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [SCALE_W-1:0]       scale_reg;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     eg_reg;
    logic                     valid_reg;
    logic [255:0]             data_reg;

    logic                     in_acc, is_data, closing, out_load;
    logic [1:0]               kind;
    act_vec_t                 act;
    logic signed [ITSUM_W-1:0] item_sum;
    logic signed [SUM_W:0]    sum_wide;
    logic [CNT_W:0]           cnt_inc;
    lane_ctrl_t               ctrl;
    logic signed [RES_W-1:0]  lane_res [4];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign kind      = s_tuser[1:0];
    assign is_data   = in_acc && (kind == KIND_DATA);
    assign cnt_inc   = (CNT_W+1)'(cnt_reg) + (CNT_W+1)'(1);
    assign closing   = s_tuser[2] || s_tlast || (cnt_inc >= (CNT_W+1)'(ITEMS_PER_BLK));
    assign out_load  = (state_reg == ST_OUT) && (!valid_reg || m_tready);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;

    // Removing the offset of 128 is a flip of the top bit.
    always_comb
    begin
        item_sum = '0;
        for (int k = 0; k < 4; k++)
        begin
            act[k] = s_tdata[128 + 8*k +: 8] ^ 8'h80;
            item_sum = item_sum + ITSUM_W'(signed'(act[k]));
        end
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(item_sum);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    always_comb
    begin
        ctrl.load_ws = in_acc && (kind == KIND_WSCALE);
        ctrl.load_mt = in_acc && (kind == KIND_MTERM);
        ctrl.acc_en  = is_data;
        ctrl.mul_en  = (state_reg == ST_MUL);
        ctrl.add_en  = (state_reg == ST_ADD);
        ctrl.sc_lo   = (state_reg == ST_SCLO);
        ctrl.sc_hi   = (state_reg == ST_SCHI);
        ctrl.sc_done = out_load;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_data && closing)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = eg_reg ? ST_SCLO : ST_IDLE;
            ST_SCLO: state_next = ST_SCHI;
            ST_SCHI: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    for (genvar r = 0; r < 4; r++)
    begin : g_lane
        gemv_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .word      (s_tdata[32*r +: 32]),
            .act       (act),
            .act_sum   (sum_reg),
            .act_scale (scale_reg),
            .result    (lane_res[r])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scale_reg <= ACT_SCALE_RST;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            eg_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                scale_reg <= cfg_data;
            end
            if (is_data)
            begin
                sum_reg <= sum_next;
                cnt_reg <= closing ? '0 : cnt_inc[CNT_W-1:0];
                eg_reg  <= s_tlast;
            end
            else if (state_reg == ST_ADD)
            begin
                sum_reg <= '0;
            end
            if (out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            data_reg <= {lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
        end
    end

endmodule
`default_nettype wire

@@ design/gemv_lane.sv @@
// One row lane: block dot product, block-end update of the row sum and group-end scaling.
`default_nettype none
module gemv_lane (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gemv_pkg::lane_ctrl_t              ctrl,
    input  wire logic [gemv_pkg::WORD_W-1:0]       word,
    input  wire gemv_pkg::act_vec_t                act,
    input  wire logic signed [gemv_pkg::SUM_W-1:0] act_sum,
    input  wire logic [gemv_pkg::SCALE_W-1:0]      act_scale,
    output logic signed [gemv_pkg::RES_W-1:0]      result
);
    import gemv_pkg::*;

    localparam int PW_W  = SCALE_W + DOT_W;
    localparam int PM_W  = SCALE_W + SUM_W;
    localparam int HALF  = ACC_W / 2;
    localparam int MUL_W = HALF + 1 + SCALE_W + 1;
    localparam int PLO_W = HALF + SCALE_W;
    localparam int PHI_W = HALF + SCALE_W + 1;
    localparam int TOT_W = PHI_W + HALF;

    logic signed [SCALE_W-1:0] ws_reg, mt_reg;
    logic signed [DOT_W-1:0]   dot_reg, dot_next;
    logic signed [PW_W-1:0]    pw_reg;
    logic signed [PM_W-1:0]    pm_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [PLO_W-1:0]          plo_reg;
    logic signed [PHI_W-1:0]   phi_reg;

    logic signed [17:0]        item_dot;
    logic signed [DOT_W:0]     dot_sum;
    logic signed [ACC_W:0]     acc_sum;
    logic signed [HALF:0]      mul_a;
    logic signed [SCALE_W:0]   mul_b;
    logic signed [MUL_W-1:0]   mul_p;
    logic [TOT_W-1:0]          tot;
    logic [TOT_W-17:0]         shifted;

    always_comb
    begin
        item_dot = '0;
        for (int k = 0; k < 4; k++)
        begin
            item_dot = item_dot + 18'(signed'(word[8*k +: 8])) * 18'(signed'(act[k]));
        end
        dot_sum = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(item_dot);
        if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
        begin
            dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
        end
        else
        begin
            dot_next = dot_sum[DOT_W-1:0];
        end
    end

    always_comb
    begin
        acc_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(pw_reg) - (ACC_W+1)'(pm_reg);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
        begin
            acc_next = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = acc_sum[ACC_W-1:0];
        end
    end

    // The 56-bit sum is scaled as two 28-bit halves through one multiplier.
    always_comb
    begin
        mul_a = ctrl.sc_lo ? {1'b0, acc_reg[HALF-1:0]} : {acc_reg[ACC_W-1], acc_reg[ACC_W-1:HALF]};
        mul_b = {1'b0, act_scale};
        mul_p = mul_a * mul_b;
    end

    // Rounds to nearest with ties upwards; only the positive side is saturated.
    always_comb
    begin
        tot = {phi_reg, {HALF{1'b0}}} + TOT_W'(plo_reg) + TOT_W'(32768);
        shifted = tot[TOT_W-1:16];
        if (!shifted[RES_W] && shifted[RES_W-1])
        begin
            result = {1'b0, {(RES_W-1){1'b1}}};
        end
        else
        begin
            result = shifted[RES_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg  <= '0;
            mt_reg  <= '0;
            dot_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            if (ctrl.load_ws)
            begin
                ws_reg <= word[SCALE_W-1:0];
            end
            if (ctrl.load_mt)
            begin
                mt_reg <= word[SCALE_W-1:0];
            end
            if (ctrl.add_en)
            begin
                dot_reg <= '0;
                acc_reg <= acc_next;
            end
            else if (ctrl.acc_en)
            begin
                dot_reg <= dot_next;
            end
            if (ctrl.sc_done)
            begin
                acc_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            pw_reg <= ws_reg * dot_reg;
            pm_reg <= mt_reg * act_sum;
        end
        if (ctrl.sc_lo)
        begin
            plo_reg <= mul_p[PLO_W-1:0];
        end
        if (ctrl.sc_hi)
        begin
            phi_reg <= mul_p[PHI_W-1:0];
        end
    end

endmodule
`default_nettype wire

@@ sim/tb_int8_block_scaled_gemv_four_rows_top.sv @@
// Self-checking testbench for the four-row block-scaled int8 GEMV stream with its own predictor.
`timescale 1ns / 100ps
module tb_int8_block_scaled_gemv_four_rows_top;
    import gemv_pkg::*;

    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam int         REQ_TARGET   = 1350;
    localparam int         BUSY_TARGET  = 1150;
    localparam int         SETTLE_CYC   = 12;
    localparam int         STALL_LIMIT  = 2000;
    localparam longint     ACC_HI       = 64'h007F_FFFF_FFFF_FFFF;
    localparam longint     ACC_LO       = 64'hFF80_0000_0000_0000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] w[4];
        logic [31:0] act;
        bit          eb;
        bit          eg;
    } gemv_req_t;

    typedef logic [3:0][63:0] row_results_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [23:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [255:0] m_tdata;

    // Predicted state of the block.
    logic [23:0]  scale_reg = ACT_SCALE_RST;
    int           dot_acc[4];
    int           act_sum;
    int           w_scale[4];
    int           m_term[4];
    longint       row_sum[4];
    int           blk_items;

    row_results_t pending_rows[$];
    int           error_count = 0;
    int           req_count = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    bit           idle_on = 1'b1;

    int8_block_scaled_gemv_four_rows_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Row sum times the Q8.16 scale, rounded half up and saturated to 64 bits.
    function automatic logic [63:0] scale_row_sum(longint acc, logic [23:0] s);
        logic signed [95:0] p;
        p = 96'(acc);
        p = p * $signed({72'd0, s}) + 96'sd32768;
        p = p >>> 16;
        if (p[95:63] != {33{p[95]}})
        begin
            return p[95] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return p[63:0];
    endfunction

    task automatic gemv_predict(input gemv_req_t q);
        int           a[4];
        int           asum;
        int           d;
        int           wb;
        int           v;
        longint       delta;
        row_results_t res;
        if (q.kind == KIND_WSCALE || q.kind == KIND_MTERM)
        begin
            for (int r = 0; r < 4; r++)
            begin
                v = int'($signed(q.w[r][23:0]));
                if (q.kind == KIND_WSCALE)
                begin
                    w_scale[r] = v;
                end
                else
                begin
                    m_term[r] = v;
                end
            end
            return;
        end
        if (q.kind != KIND_DATA)
        begin
            return;
        end
        asum = 0;
        for (int k = 0; k < 4; k++)
        begin
            a[k] = int'(q.act[8*k +: 8]) - 128;
            asum += a[k];
        end
        act_sum = int'(clamp_range(longint'(act_sum + asum), longint'(-4096), longint'(4095)));
        for (int r = 0; r < 4; r++)
        begin
            d = 0;
            for (int k = 0; k < 4; k++)
            begin
                wb = int'($signed(q.w[r][8*k +: 8]));
                d += wb * a[k];
            end
            dot_acc[r] = int'(clamp_range(longint'(dot_acc[r] + d), longint'(-1048576),
                                          longint'(1048575)));
        end
        blk_items++;
        // A block closes on its flag, on the group end, or when it is full.
        if (q.eb || q.eg || blk_items >= ITEMS_PER_BLK)
        begin
            for (int r = 0; r < 4; r++)
            begin
                delta = longint'(w_scale[r]) * longint'(dot_acc[r])
                      - longint'(m_term[r]) * longint'(act_sum);
                row_sum[r] = clamp_range(row_sum[r] + delta, ACC_LO, ACC_HI);
                dot_acc[r] = 0;
            end
            act_sum = 0;
            blk_items = 0;
        end
        if (q.eg)
        begin
            for (int r = 0; r < 4; r++)
            begin
                res[r] = scale_row_sum(row_sum[r], scale_reg);
                row_sum[r] = 0;
            end
            pending_rows.push_back(res);
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic gemv_req_t make_req(logic [1:0] kind, logic [31:0] w0, logic [31:0] w1,
                                           logic [31:0] w2, logic [31:0] w3, logic [31:0] act,
                                           bit eb, bit eg);
        gemv_req_t q;
        q.kind = kind;
        q.w[0] = w0;
        q.w[1] = w1;
        q.w[2] = w2;
        q.w[3] = w3;
        q.act  = act;
        q.eb   = eb;
        q.eg   = eg;
        return q;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h8080_8080;
            1: return 32'h7F7F_7F7F;
            default: return $urandom;
        endcase
    endfunction

    // Header words favour the ends of the Q2.22 range; the upper byte is junk.
    function automatic logic [31:0] pick_header_word();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(0, 7))
            0: x[23:0] = 24'h7F_FFFF;
            1: x[23:0] = 24'h80_0000;
            2: x[23:0] = 24'h40_0000;
            default: ;
        endcase
        return x;
    endfunction

    task automatic send_req(input gemv_req_t q);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q.act, q.w[3], q.w[2], q.w[1], q.w[0]};
        s_tuser  <= {q.eb, q.kind};
        s_tlast  <= q.eg;
        do
            @(posedge clk);
        while (!s_tready);
        gemv_predict(q);
        if (q.kind != KIND_SPARE)
        begin
            req_count++;
        end
    endtask

    // Stops the sender and lets every expected result come out.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_rows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_act_scale(input logic [23:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        scale_reg = v;
    endtask

    task automatic send_header(input logic [1:0] kind);
        send_req(make_req(kind, pick_header_word(), pick_header_word(), pick_header_word(),
                          pick_header_word(), $urandom, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1))));
    endtask

    // One group of one to four blocks, mostly well formed, with some noise mixed in.
    task automatic send_random_group();
        int  nblk;
        int  len;
        bit  eb;
        bit  eg;
        nblk = $urandom_range(1, 4);
        if ($urandom_range(0, 3) != 0)
        begin
            send_header(KIND_WSCALE);
        end
        if ($urandom_range(0, 3) != 0)
        begin
            send_header(KIND_MTERM);
        end
        for (int b = 0; b < nblk; b++)
        begin
            len = ($urandom_range(0, 9) == 0) ? ITEMS_PER_BLK : $urandom_range(1, ITEMS_PER_BLK);
            for (int i = 0; i < len; i++)
            begin
                eg = (b == nblk - 1) && (i == len - 1);
                if (i == len - 1)
                begin
                    eb = ($urandom_range(0, 4) != 0);
                end
                else
                begin
                    eb = ($urandom_range(0, 24) == 0);
                end
                send_req(make_req(KIND_DATA, pick_word(), pick_word(), pick_word(), pick_word(),
                                  pick_word(), eb, eg));
                if ($urandom_range(0, 29) == 0)
                begin
                    send_req(make_req(KIND_SPARE, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    send_header($urandom_range(0, 1) ? KIND_WSCALE : KIND_MTERM);
                end
            end
        end
    endtask

    task automatic test_directed_edges();
        send_req(make_req(KIND_WSCALE, 32'h007F_FFFF, 32'hFF80_0000, 32'hAB00_0001,
                          32'h5A40_0000, 32'h0, 1'b1, 1'b1));
        send_req(make_req(KIND_MTERM, 32'h0000_0001, 32'h00FF_FFFF, 32'h007F_FFFF,
                          32'hC380_0000, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_req(make_req(KIND_SPARE, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1));
        send_req(make_req(KIND_DATA, 32'h8080_8080, 32'h7F7F_7F7F, 32'h807F_0180, 32'h0,
                          32'h0000_0000, 1'b0, 1'b0));
        send_req(make_req(KIND_DATA, 32'h7F7F_7F7F, 32'h8080_8080, 32'hFF01_FF01, 32'h1234_5678,
                          32'hFFFF_FFFF, 1'b1, 1'b0));
        // Group end with no block end flag.
        send_req(make_req(KIND_DATA, $urandom, $urandom, $urandom, $urandom,
                          32'h8080_8080, 1'b0, 1'b1));
        // A full block closes by itself, then one more request ends the group.
        for (int i = 0; i < ITEMS_PER_BLK; i++)
        begin
            send_req(make_req(KIND_DATA, 32'h8080_8080, 32'h7F7F_7F7F, 32'h8080_8080,
                              32'h7F7F_7F7F, 32'h0000_0000, 1'b0, 1'b0));
        end
        send_req(make_req(KIND_DATA, 32'h7F7F_7F7F, 32'h8080_8080, 32'h0101_0101, 32'hFEFE_FEFE,
                          32'hFFFF_FFFF, 1'b1, 1'b1));
        send_req(make_req(KIND_WSCALE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
        send_req(make_req(KIND_DATA, $urandom, $urandom, $urandom, $urandom, $urandom,
                          1'b0, 1'b1));
    endtask

    task automatic test_scale_extremes();
        logic [23:0] settings[5];
        settings = '{24'h00_0000, 24'hFF_FFFF, 24'h00_0001, 24'h0, ACT_SCALE_RST};
        settings[3] = 24'($urandom);
        foreach (settings[i])
        begin
            drain_block();
            write_act_scale(settings[i]);
            repeat (3) send_random_group();
        end
    endtask

    task automatic test_random_stream();
        while (req_count < BUSY_TARGET)
        begin
            send_random_group();
            // Now and then the sender holds off until all results are out and the scale changes.
            if ($urandom_range(0, 24) == 0)
            begin
                drain_block();
                write_act_scale(24'($urandom));
            end
        end
    endtask

    task automatic test_quiet_tail();
        drain_block();
        write_act_scale(24'($urandom));
        idle_on = 1'b0;
        while (req_count < REQ_TARGET)
        begin
            send_random_group();
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end
        else if (rst_n && idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(1, 4);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        row_results_t got;
        row_results_t want;
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_rows.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing expected: %h", got));
            end
            else
            begin
                want = pending_rows.pop_front();
                for (int r = 0; r < 4; r++)
                begin
                    if (got[r] !== want[r])
                    begin
                        report_mismatch($sformatf("row%0d_result got %h want %h",
                                                  r, got[r], want[r]));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_int8_block_scaled_gemv_four_rows_top: done, errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        for (int r = 0; r < 4; r++)
        begin
            dot_acc[r] = 0;
            w_scale[r] = 0;
            m_term[r]  = 0;
            row_sum[r] = 0;
        end
        act_sum   = 0;
        blk_items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_scale_extremes();
        test_random_stream();
        test_quiet_tail();
        drain_block();
        if (pending_rows.size() != 0)
        begin
            report_mismatch("expected results never arrived");
        end
        if (error_count == 0)
        begin
            $display("tb_int8_block_scaled_gemv_four_rows_top: done, clean");
        end
        else
        begin
            $display("tb_int8_block_scaled_gemv_four_rows_top: done, errors");
        end
        $finish;
    end

endmodule
